/* src/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent checks sampled on clk_i, quiet while rst_ni is low
`ifndef NO_ASSERTIONS
`define BDQ_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define BDQ_ASSERT_MSG(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
`else
`define BDQ_ASSERT(name, prop)
`define BDQ_ASSERT_MSG(name, prop, msg)
`endif

`endif

/* src/bdq_pkg.sv */
package bdq_pkg;

  localparam int DEPTH = 16;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int DW    = 32;
  localparam int CMD_W = 3;
  localparam int CNT_W = 5;
  localparam int ST_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_POP_BACK   = 3'd1,
    CMD_PUSH_FRONT = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_DELETE     = 3'd4
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOMATCH = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POPRD,
    S_SRCH,
    S_SHIFT,
    S_RESP
  } state_e;

  // head plus offset, modulo the ring size; the sum stays below twice the size
  function automatic logic [AW-1:0] bdq_wrap(input logic [AW:0] sum);
    logic [AW:0] lim;
    lim = (AW+1)'(DEPTH);
    if (sum >= lim) begin
      return AW'(sum - lim);
    end
    return AW'(sum);
  endfunction

  function automatic logic [AW-1:0] bdq_phys(input logic [AW-1:0] head,
                                             input logic [AW-1:0] pos);
    return bdq_wrap({1'b0, head} + {1'b0, pos});
  endfunction

  function automatic logic [AW-1:0] bdq_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] bdq_dec(input logic [AW-1:0] p);
    return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
  endfunction

endpackage

/* src/bdq_if.sv */
interface bdq_cmd_if import bdq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic signed [DW-1:0]    value;

  modport source (output valid, output command, output value, input ready);
  modport sink (input valid, input command, input value, output ready);
endinterface

interface bdq_res_if import bdq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DW-1:0]    popped;
  logic [CNT_W-1:0]        count;
  logic [ST_W-1:0]         status;

  modport source (output valid, output popped, output count, output status, input ready);
  modport sink (input valid, input popped, input count, input status, output ready);
endinterface

/* src/bdq_ram.sv */
module bdq_ram #(
  parameter int DATA_W = 32,
  parameter int WORDS  = 16,
  parameter int ADDR_W = $clog2(WORDS)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [WORDS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

/* src/bounded_deque_with_delete_top.sv */
// Bounded double-ended queue of DEPTH signed 32-bit words held as a ring in one
// single-port-read, single-port-write RAM. One command is worked at a time. A push
// writes the entry RAM when it is accepted and a pop reads it then; a delete that
// matches at position p of n entries makes p + 1 reads to find the match, then
// n - 1 - p read-then-write steps to close the gap, and a miss makes n reads. The
// entry RAM gives one read and one write per cycle. The next command is taken
// while the previous result waits in the output register.
`include "assert_macros.svh"

module bounded_deque_with_delete_top import bdq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  bdq_cmd_if.sink    cmd_i,
  bdq_res_if.source  res_o
);

  state_e        state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [DW-1:0] key_q, key_d;
  logic [DW-1:0] r_popped_q, r_popped_d;
  status_e       r_status_q, r_status_d;

  logic             res_valid_q, res_valid_d;
  logic [DW-1:0]    res_popped_q;
  logic [CNT_W-1:0] res_count_q;
  status_e          res_status_q;
  logic             res_load;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata;

  logic [AW-1:0] last_pos, pos_nxt, pos_nxt2;
  logic          is_full, is_empty;

  bdq_ram #(
    .DATA_W (DW),
    .WORDS  (DEPTH),
    .ADDR_W (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign last_pos = AW'(fill_q - CW'(1));
  assign pos_nxt  = pos_q + AW'(1);
  assign pos_nxt2 = pos_q + AW'(2);
  assign is_full  = (fill_q == CW'(DEPTH));
  assign is_empty = (fill_q == '0);

  assign cmd_i.ready = (state_q == S_IDLE);
  assign res_load    = (state_q == S_RESP) && (!res_valid_q || res_o.ready);

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    fill_d     = fill_q;
    pos_d      = pos_q;
    key_d      = key_q;
    r_popped_d = r_popped_q;
    r_status_d = r_status_q;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = cmd_i.value;
    ram_re     = 1'b0;
    ram_raddr  = head_q;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          r_popped_d = '0;
          r_status_d = ST_OK;
          state_d    = S_RESP;
          case (cmd_i.command)
            CMD_PUSH_BACK: begin
              if (is_full) begin
                r_status_d = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = bdq_phys(head_q, AW'(fill_q));
                fill_d    = fill_q + CW'(1);
              end
            end
            CMD_PUSH_FRONT: begin
              if (is_full) begin
                r_status_d = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = bdq_dec(head_q);
                head_d    = bdq_dec(head_q);
                fill_d    = fill_q + CW'(1);
              end
            end
            CMD_POP_BACK: begin
              if (is_empty) begin
                r_status_d = ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = bdq_phys(head_q, last_pos);
                fill_d    = fill_q - CW'(1);
                state_d   = S_POPRD;
              end
            end
            CMD_POP_FRONT: begin
              if (is_empty) begin
                r_status_d = ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = head_q;
                head_d    = bdq_inc(head_q);
                fill_d    = fill_q - CW'(1);
                state_d   = S_POPRD;
              end
            end
            CMD_DELETE: begin
              if (is_empty) begin
                r_status_d = ST_NOMATCH;
              end else begin
                key_d     = cmd_i.value;
                pos_d     = '0;
                ram_re    = 1'b1;
                ram_raddr = head_q;
                state_d   = S_SRCH;
              end
            end
            default: ;
          endcase
        end
      end
      S_POPRD: begin
        r_popped_d = ram_rdata;
        state_d    = S_RESP;
      end
      // ram_rdata holds the entry at pos_q
      S_SRCH: begin
        if (ram_rdata == key_q) begin
          if (pos_q == last_pos) begin
            fill_d  = fill_q - CW'(1);
            state_d = S_RESP;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = bdq_phys(head_q, pos_nxt);
            state_d   = S_SHIFT;
          end
        end else if (pos_q == last_pos) begin
          r_status_d = ST_NOMATCH;
          state_d    = S_RESP;
        end else begin
          pos_d     = pos_nxt;
          ram_re    = 1'b1;
          ram_raddr = bdq_phys(head_q, pos_nxt);
        end
      end
      // ram_rdata holds the entry at pos_q + 1, moved down one place
      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = bdq_phys(head_q, pos_q);
        ram_wdata = ram_rdata;
        if (pos_nxt == last_pos) begin
          fill_d  = fill_q - CW'(1);
          state_d = S_RESP;
        end else begin
          pos_d     = pos_nxt;
          ram_re    = 1'b1;
          ram_raddr = bdq_phys(head_q, pos_nxt2);
        end
      end
      S_RESP: begin
        if (res_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    key_q      <= key_d;
    r_popped_q <= r_popped_d;
    r_status_q <= r_status_d;
  end

  // output register
  always_comb begin
    res_valid_d = res_valid_q;
    if (res_load) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_popped_q <= r_popped_q;
      res_count_q  <= CNT_W'(fill_q);
      res_status_q <= r_status_q;
    end
  end

  assign res_o.valid  = res_valid_q;
  assign res_o.popped = res_popped_q;
  assign res_o.count  = res_count_q;
  assign res_o.status = res_status_q;

  `BDQ_ASSERT_MSG(a_fill_bound, fill_q <= CW'(DEPTH), "fill beyond depth")
  `BDQ_ASSERT(a_accept_leaves_idle, (cmd_i.valid && cmd_i.ready) |=> (state_q != S_IDLE))
  `BDQ_ASSERT_MSG(a_shift_needs_two, (state_q == S_SHIFT) |-> (fill_q >= CW'(2)), "shift underflow")
  `BDQ_ASSERT(a_poprd_after_idle, (state_q == S_POPRD) |-> ($past(state_q) == S_IDLE))

endmodule
